// File: src/i2cm_pkg.sv
package i2cm_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int DELAY_WIDTH_DEF = 16;
  localparam int HALF_W = 16;
  localparam int ADDR_W = 8;
  localparam int BYTE_W = 8;
  localparam int ACT_W = 2;
  localparam int STAT_W = 2;
  localparam int BCNT_W = 16;

  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RSVD  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_ADDR_NACK = 2'd1;
  localparam logic [STAT_W-1:0] ST_DATA_NACK = 2'd2;

  localparam logic [BYTE_W-1:0] MSB_MASK = 8'h80;

  // one tick after the front end has sorted the command
  typedef struct packed {
    logic              start_wr;
    logic              start_rd;
    logic [ADDR_W-1:0] addr;
    logic [BCNT_W-1:0] count;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_ready;
    logic              sda;
  } tick_t;

endpackage

// File: src/i2cm_front.sv
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [ADDR_W-1:0] in_dev_addr,
  input  logic [BCNT_W-1:0] in_byte_count,
  input  logic [BYTE_W-1:0] in_tx_byte,
  input  logic              in_tx_ready,
  input  logic              in_sda_in,
  output logic              q_valid,
  input  logic              q_pop,
  output tick_t             q_tick
);

  // two-entry queue between classification and the bus engine
  tick_t     mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  tick_t     cls;
  logic      push;

  always_comb begin
    cls.start_wr = (in_action == ACT_WRITE);
    cls.start_rd = (in_action == ACT_READ);
    cls.addr     = in_dev_addr;
    cls.count    = in_byte_count;
    cls.tx_byte  = in_tx_byte;
    cls.tx_ready = in_tx_ready;
    cls.sda      = in_sda_in;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_tick   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// File: src/i2cm_engine.sv
module i2cm_engine
  import i2cm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DELAY_WIDTH-1:0] half_period,
  input  logic              q_valid,
  output logic              q_pop,
  input  tick_t             q_tick,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_scl_release,
  output logic              out_sda_release,
  output logic              out_tx_take,
  output logic [BYTE_W-1:0] out_rx_byte,
  output logic              out_rx_valid,
  output logic              out_done_res,
  output logic [STAT_W-1:0] out_status,
  output logic              out_busy_res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_TX_LO, PH_TX_HI,
    PH_ACK_LO, PH_ACK_HI, PH_WAIT_TX, PH_RX_LO, PH_RX_HI,
    PH_MACK_LO, PH_MACK_HI, PH_STOP_A, PH_STOP_B
  } phase_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  phase_t                  phase_r, phase_nxt;
  logic [DELAY_WIDTH-1:0]  dly_r, dly_nxt;
  logic [3:0]              bit_r, bit_nxt;
  logic [BYTE_W-1:0]       sh_r, sh_nxt;
  logic [COUNT_WIDTH-1:0]  left_r, left_nxt;
  logic                    rd_r, rd_nxt, ab_r, ab_nxt;
  logic [STAT_W-1:0]       err_r, err_nxt;
  logic                    scl_r, scl_nxt, sda_r, sda_nxt;
  logic                    take, rxv, done;
  logic [BYTE_W-1:0]       rxb;
  logic [STAT_W-1:0]       stat;
  logic [COUNT_WIDTH-1:0]  cnt_in;
  logic [DELAY_WIDTH:0]    dly_inc;
  logic [BYTE_W-1:0]       sh_tmp;
  logic [3:0]              bit_tmp;
  logic                    step;

  // output register; a new tick enters when it is empty or being taken
  logic ov_r;
  assign step = q_valid && (!ov_r || !out_stall);
  assign q_pop = step;
  assign out_valid = ov_r;

  always_comb begin
    if (COUNT_WIDTH >= BCNT_W)
      cnt_in = COUNT_WIDTH'(q_tick.count);
    else if (q_tick.count > BCNT_W'(CNT_MAX))
      cnt_in = CNT_MAX;
    else
      cnt_in = q_tick.count[COUNT_WIDTH-1:0];
  end

  function automatic void drive(input phase_t ph, input logic [BYTE_W-1:0] sb,
                                input logic zero_left, output logic c, output logic d);
    unique case (ph)
      PH_START_B: begin c = 1'b1; d = 1'b0; end
      PH_TX_LO:   begin c = 1'b0; d = |(sb & MSB_MASK); end
      PH_TX_HI:   begin c = 1'b1; d = |(sb & MSB_MASK); end
      PH_ACK_LO, PH_WAIT_TX, PH_RX_LO: begin c = 1'b0; d = 1'b1; end
      PH_ACK_HI, PH_RX_HI: begin c = 1'b1; d = 1'b1; end
      PH_MACK_LO: begin c = 1'b0; d = zero_left; end
      PH_MACK_HI: begin c = 1'b1; d = zero_left; end
      PH_STOP_A:  begin c = 1'b0; d = 1'b0; end
      PH_STOP_B:  begin c = 1'b1; d = 1'b0; end
      default:    begin c = 1'b1; d = 1'b1; end
    endcase
  endfunction

  always_comb begin
    phase_nxt = phase_r; dly_nxt = dly_r; bit_nxt = bit_r; sh_nxt = sh_r;
    left_nxt = left_r; rd_nxt = rd_r; ab_nxt = ab_r; err_nxt = err_r;
    scl_nxt = scl_r; sda_nxt = sda_r;
    take = 1'b0; rxv = 1'b0; done = 1'b0; rxb = '0; stat = ST_OK;
    dly_inc = {1'b0, dly_r} + 1'b1;
    sh_tmp = '0; bit_tmp = '0;
    if (phase_r == PH_IDLE) begin
      if (q_tick.start_wr || q_tick.start_rd) begin
        rd_nxt = q_tick.start_rd;
        ab_nxt = 1'b1;
        err_nxt = ST_OK;
        bit_nxt = '0;
        sh_nxt = q_tick.start_rd ? (q_tick.addr | 8'h01) : q_tick.addr;
        left_nxt = (q_tick.start_rd && cnt_in == '0) ? COUNT_WIDTH'(1) : cnt_in;
        phase_nxt = PH_START_A;
        dly_nxt = '0;
        scl_nxt = 1'b1; sda_nxt = 1'b1;
      end
    end else if (phase_r == PH_WAIT_TX) begin
      if (q_tick.tx_ready) begin
        take = 1'b1; sh_nxt = q_tick.tx_byte; bit_nxt = '0;
        left_nxt = left_r - 1'b1; phase_nxt = PH_TX_LO;
      end
    end else if (dly_inc < {1'b0, half_period}) begin
      dly_nxt = dly_inc[DELAY_WIDTH-1:0];
    end else begin
      unique case (phase_r)
        PH_START_A: phase_nxt = PH_START_B;
        PH_START_B: phase_nxt = PH_TX_LO;
        PH_TX_LO:   phase_nxt = PH_TX_HI;
        PH_TX_HI: begin
          sh_nxt = sh_r << 1;
          bit_nxt = bit_r + 1'b1;
          phase_nxt = (bit_nxt >= 4'd8) ? PH_ACK_LO : PH_TX_LO;
        end
        PH_ACK_LO: phase_nxt = PH_ACK_HI;
        PH_ACK_HI: begin
          if (q_tick.sda) begin
            err_nxt = ab_r ? ST_ADDR_NACK : ST_DATA_NACK;
            phase_nxt = PH_STOP_A;
          end else if (ab_r && rd_r) begin
            ab_nxt = 1'b0; sh_nxt = '0; bit_nxt = '0; phase_nxt = PH_RX_LO;
          end else begin
            ab_nxt = 1'b0;
            if (left_r == '0) phase_nxt = PH_STOP_A;
            else if (q_tick.tx_ready) begin
              take = 1'b1; sh_nxt = q_tick.tx_byte; bit_nxt = '0;
              left_nxt = left_r - 1'b1; phase_nxt = PH_TX_LO;
            end else phase_nxt = PH_WAIT_TX;
          end
        end
        PH_RX_LO: phase_nxt = PH_RX_HI;
        PH_RX_HI: begin
          sh_tmp = {sh_r[BYTE_W-2:0], q_tick.sda};
          bit_tmp = bit_r + 1'b1;
          sh_nxt = sh_tmp; bit_nxt = bit_tmp;
          if (bit_tmp >= 4'd8) begin
            rxb = sh_tmp; rxv = 1'b1; left_nxt = left_r - 1'b1;
            phase_nxt = PH_MACK_LO;
          end else phase_nxt = PH_RX_LO;
        end
        PH_MACK_LO: phase_nxt = PH_MACK_HI;
        PH_MACK_HI: begin
          if (left_r != '0) begin
            sh_nxt = '0; bit_nxt = '0; phase_nxt = PH_RX_LO;
          end else phase_nxt = PH_STOP_A;
        end
        PH_STOP_A: phase_nxt = PH_STOP_B;
        PH_STOP_B: begin
          done = 1'b1; stat = err_r; phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
      dly_nxt = '0;
      drive(phase_nxt, sh_nxt, left_nxt == '0, scl_nxt, sda_nxt);
    end
    if (take) begin
      dly_nxt = '0;
      drive(PH_TX_LO, sh_nxt, 1'b0, scl_nxt, sda_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; dly_r <= '0; bit_r <= '0; sh_r <= '0; left_r <= '0;
      rd_r <= 1'b0; ab_r <= 1'b0; err_r <= ST_OK; scl_r <= 1'b1; sda_r <= 1'b1;
      ov_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt; dly_r <= dly_nxt; bit_r <= bit_nxt; sh_r <= sh_nxt;
        left_r <= left_nxt; rd_r <= rd_nxt; ab_r <= ab_nxt; err_r <= err_nxt;
        scl_r <= scl_nxt; sda_r <= sda_nxt;
      end
      if (step) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_scl_release <= scl_nxt;
      out_sda_release <= sda_nxt;
      out_tx_take     <= take;
      out_rx_byte     <= rxb;
      out_rx_valid    <= rxv;
      out_done_res    <= done;
      out_status      <= stat;
      out_busy_res    <= (phase_nxt != PH_IDLE);
    end
  end

endmodule

// File: src/i2c_master_transaction_engine.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | action, dev_addr, byte_count, tx_byte, tx_ready, sda_in
// out_    | output    | out_valid/out_stall| scl/sda release, tx_take, rx, done, status, busy
// cfg_    | input     | cfg_valid/cfg_ready| half_period_ticks
// one tick is accepted per clock while in_stall is low; each result is registered first in
// the two-entry front queue and then in the engine's output register
// synchronous active-low reset returns the bus to released, idle
// an output stall backs up into the queue, then stalls the input after two ticks
module i2c_master_transaction_engine
  import i2cm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [HALF_W-1:0] cfg_half_period_ticks,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [ADDR_W-1:0] in_dev_addr,
  input  logic [BCNT_W-1:0] in_byte_count,
  input  logic [BYTE_W-1:0] in_tx_byte,
  input  logic              in_tx_ready,
  input  logic              in_sda_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_scl_release,
  output logic              out_sda_release,
  output logic              out_tx_take,
  output logic [BYTE_W-1:0] out_rx_byte,
  output logic              out_rx_valid,
  output logic              out_done_res,
  output logic [STAT_W-1:0] out_status,
  output logic              out_busy_res
);

  localparam logic [DELAY_WIDTH-1:0] DLY_MAX = {DELAY_WIDTH{1'b1}};

  logic [DELAY_WIDTH-1:0] half_r;
  logic [DELAY_WIDTH-1:0] half_nxt;
  logic   q_valid, q_pop;
  tick_t  q_tick;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_half_period_ticks == '0) half_nxt = DELAY_WIDTH'(1);
    else if (DELAY_WIDTH >= HALF_W) half_nxt = DELAY_WIDTH'(cfg_half_period_ticks);
    else if (cfg_half_period_ticks > HALF_W'(DLY_MAX)) half_nxt = DLY_MAX;
    else half_nxt = cfg_half_period_ticks[DELAY_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) half_r <= DELAY_WIDTH'(1);
    else if (cfg_valid) half_r <= half_nxt;
  end

  i2cm_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_dev_addr, .in_byte_count,
    .in_tx_byte, .in_tx_ready, .in_sda_in, .q_valid, .q_pop, .q_tick
  );

  i2cm_engine #(.COUNT_WIDTH(COUNT_WIDTH), .DELAY_WIDTH(DELAY_WIDTH)) u_engine (
    .clk, .rst_n, .half_period(half_r), .q_valid, .q_pop, .q_tick,
    .out_valid, .out_stall, .out_scl_release, .out_sda_release, .out_tx_take,
    .out_rx_byte, .out_rx_valid, .out_done_res, .out_status, .out_busy_res
  );

endmodule

// File: src/i2cm_checker.sv
module i2cm_checker
  import i2cm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_scl_release,
  input logic              out_sda_release,
  input logic              out_tx_take,
  input logic              out_rx_valid,
  input logic              out_done_res,
  input logic [STAT_W-1:0] out_status,
  input logic              out_busy_res
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scl_release) && $stable(out_status))
    else $error("stalled result changed");

  // the bus is released on both lines once a transaction ends
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && out_scl_release && out_sda_release)
    else $error("done while busy");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_status == ST_OK)
    else $error("status without done");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_tx_take, out_rx_valid, out_done_res}))
    else $error("events overlap");

endmodule

bind i2c_master_transaction_engine i2cm_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_scl_release, .out_sda_release,
  .out_tx_take, .out_rx_valid, .out_done_res, .out_status, .out_busy_res
);

// File: sim/tb_top.sv
module tb_top;
  import i2cm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    BUS_IDLE, BUS_START_A, BUS_START_B, BUS_TX_LO, BUS_TX_HI,
    BUS_ACK_LO, BUS_ACK_HI, BUS_WAIT_TX, BUS_RX_LO, BUS_RX_HI,
    BUS_MACK_LO, BUS_MACK_HI, BUS_STOP_A, BUS_STOP_B
  } bus_phase_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] addr;
    logic [BCNT_W-1:0] count;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_ready;
    logic              sda;
  } tick_item_t;

  typedef struct packed {
    logic              scl;
    logic              sda;
    logic              take;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_valid;
    logic              done;
    logic [STAT_W-1:0] status;
    logic              busy;
  } pin_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [HALF_W-1:0] cfg_half_period_ticks = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACT_W-1:0] in_action = '0;
  logic [ADDR_W-1:0] in_dev_addr = '0;
  logic [BCNT_W-1:0] in_byte_count = '0;
  logic [BYTE_W-1:0] in_tx_byte = '0;
  logic in_tx_ready = 1'b0;
  logic in_sda_in = 1'b1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_scl_release, out_sda_release, out_tx_take, out_rx_valid;
  logic out_done_res, out_busy_res;
  logic [BYTE_W-1:0] out_rx_byte;
  logic [STAT_W-1:0] out_status;

  i2c_master_transaction_engine dut (.*);

  always #5 clk = ~clk;

  // predictor state
  bus_phase_t bus_phase;
  int unsigned half_ticks, wait_cnt, bit_pos, shreg, remaining;
  bit rd_mode, on_addr;
  logic [STAT_W-1:0] err_kept;
  bit scl_lvl, sda_lvl;

  tick_item_t tick_q[$];
  pin_result_t pins_expected[$];
  int errors = 0;
  bit quiet = 1'b0;
  int hold_off = 0;

  function automatic void predictor_reset();
    half_ticks = 1; bus_phase = BUS_IDLE; wait_cnt = 0; bit_pos = 0; shreg = 0;
    remaining = 0; rd_mode = 0; on_addr = 0; err_kept = ST_OK; scl_lvl = 1; sda_lvl = 1;
  endfunction

  function automatic void go_phase(bus_phase_t ph);
    bit msb;
    msb = (shreg & MSB_MASK) != 0;
    bus_phase = ph;
    wait_cnt = 0;
    case (ph)
      BUS_START_B: begin scl_lvl = 1; sda_lvl = 0; end
      BUS_TX_LO: begin scl_lvl = 0; sda_lvl = msb; end
      BUS_TX_HI: begin scl_lvl = 1; sda_lvl = msb; end
      BUS_ACK_LO, BUS_WAIT_TX, BUS_RX_LO: begin scl_lvl = 0; sda_lvl = 1; end
      BUS_ACK_HI, BUS_RX_HI: begin scl_lvl = 1; sda_lvl = 1; end
      BUS_MACK_LO: begin scl_lvl = 0; sda_lvl = remaining == 0; end
      BUS_MACK_HI: begin scl_lvl = 1; sda_lvl = remaining == 0; end
      BUS_STOP_A: begin scl_lvl = 0; sda_lvl = 0; end
      BUS_STOP_B: begin scl_lvl = 1; sda_lvl = 0; end
      default: begin scl_lvl = 1; sda_lvl = 1; end
    endcase
  endfunction

  function automatic bit load_tx(tick_item_t t);
    if (!t.tx_ready) return 0;
    shreg = int'(t.tx_byte);
    bit_pos = 0;
    remaining = (remaining - 1) & 16'hFFFF;
    go_phase(BUS_TX_LO);
    return 1;
  endfunction

  function automatic pin_result_t predict_pins(tick_item_t t);
    pin_result_t r;
    r = '0;
    if (bus_phase == BUS_IDLE) begin
      if (t.action == ACT_WRITE || t.action == ACT_READ) begin
        rd_mode = t.action == ACT_READ;
        on_addr = 1; err_kept = ST_OK; bit_pos = 0;
        shreg = rd_mode ? int'(t.addr | 8'h01) : int'(t.addr);
        remaining = (rd_mode && t.count == '0) ? 1 : int'(t.count);
        bus_phase = BUS_START_A; wait_cnt = 0; scl_lvl = 1; sda_lvl = 1;
      end
    end else if (bus_phase == BUS_WAIT_TX) begin
      r.take = load_tx(t);
    end else if (wait_cnt + 1 < half_ticks) begin
      wait_cnt++;
    end else begin
      case (bus_phase)
        BUS_START_A: go_phase(BUS_START_B);
        BUS_START_B: go_phase(BUS_TX_LO);
        BUS_TX_LO: go_phase(BUS_TX_HI);
        BUS_TX_HI: begin
          shreg = (shreg << 1) & 8'hFF;
          bit_pos++;
          go_phase(bit_pos >= 8 ? BUS_ACK_LO : BUS_TX_LO);
        end
        BUS_ACK_LO: go_phase(BUS_ACK_HI);
        BUS_ACK_HI: begin
          if (t.sda) begin
            err_kept = on_addr ? ST_ADDR_NACK : ST_DATA_NACK;
            go_phase(BUS_STOP_A);
          end else if (on_addr && rd_mode) begin
            on_addr = 0; shreg = 0; bit_pos = 0;
            go_phase(BUS_RX_LO);
          end else begin
            on_addr = 0;
            if (remaining == 0) go_phase(BUS_STOP_A);
            else if (load_tx(t)) r.take = 1;
            else go_phase(BUS_WAIT_TX);
          end
        end
        BUS_RX_LO: go_phase(BUS_RX_HI);
        BUS_RX_HI: begin
          shreg = ((shreg << 1) | t.sda) & 8'hFF;
          bit_pos++;
          if (bit_pos >= 8) begin
            r.rx_byte = BYTE_W'(shreg); r.rx_valid = 1;
            remaining = (remaining - 1) & 16'hFFFF;
            go_phase(BUS_MACK_LO);
          end else go_phase(BUS_RX_LO);
        end
        BUS_MACK_LO: go_phase(BUS_MACK_HI);
        BUS_MACK_HI: begin
          if (remaining != 0) begin
            shreg = 0; bit_pos = 0; go_phase(BUS_RX_LO);
          end else go_phase(BUS_STOP_A);
        end
        BUS_STOP_A: go_phase(BUS_STOP_B);
        BUS_STOP_B: begin
          r.done = 1; r.status = err_kept; go_phase(BUS_IDLE);
        end
        default: go_phase(BUS_IDLE);
      endcase
    end
    r.scl = scl_lvl; r.sda = sda_lvl; r.busy = bus_phase != BUS_IDLE;
    return r;
  endfunction

  function automatic tick_item_t rand_tick(bit cmd_ok, bit ack_bias);
    tick_item_t t;
    t.action = cmd_ok ? ACT_W'($urandom_range(3, 0)) : ACT_TICK;
    t.addr = ADDR_W'($urandom);
    // mostly short transfers, rare huge counts for the top bits
    t.count = ($urandom_range(40, 0) == 0) ? BCNT_W'($urandom) : BCNT_W'($urandom_range(3, 0));
    t.tx_byte = BYTE_W'($urandom);
    t.tx_ready = $urandom_range(3, 0) != 0;
    t.sda = ack_bias ? ($urandom_range(9, 0) == 0) : ($urandom_range(1, 0) == 1);
    return t;
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_valid && !in_stall) void'(tick_q.pop_front());
      if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if ((in_valid && !in_stall ? tick_q.size() : tick_q.size()) > 0 &&
                   !(!quiet && $urandom_range(9, 0) == 0)) begin
        in_valid <= 1'b1;
        {in_action, in_dev_addr, in_byte_count, in_tx_byte, in_tx_ready, in_sda_in}
          <= tick_q[0];
      end else begin
        in_valid <= 1'b0;
        if (!quiet && tick_q.size() > 0) gap <= $urandom_range(3, 0);
      end
    end
  end

  // prediction on accepted transactions
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pins_expected.push_back(predict_pins({in_action, in_dev_addr, in_byte_count,
                                            in_tx_byte, in_tx_ready, in_sda_in}));
  end

  // receiver back-pressure
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(7, 0) == 0) begin
      stall_left <= $urandom_range(3, 0);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    pin_result_t got, exp_r;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_scl_release, out_sda_release, out_tx_take, out_rx_byte, out_rx_valid,
             out_done_res, out_status, out_busy_res};
      if (pins_expected.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        exp_r = pins_expected.pop_front();
        if (got.scl !== exp_r.scl) begin
          $error("scl_release exp %0d got %0d", exp_r.scl, got.scl); errors++; end
        if (got.sda !== exp_r.sda) begin
          $error("sda_release exp %0d got %0d", exp_r.sda, got.sda); errors++; end
        if (got.take !== exp_r.take) begin
          $error("tx_take exp %0d got %0d", exp_r.take, got.take); errors++; end
        if (got.rx_byte !== exp_r.rx_byte) begin
          $error("rx_byte exp %0h got %0h", exp_r.rx_byte, got.rx_byte); errors++; end
        if (got.rx_valid !== exp_r.rx_valid) begin
          $error("rx_valid exp %0d got %0d", exp_r.rx_valid, got.rx_valid); errors++; end
        if (got.done !== exp_r.done) begin
          $error("done_res exp %0d got %0d", exp_r.done, got.done); errors++; end
        if (got.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); errors++; end
        if (got.busy !== exp_r.busy) begin
          $error("busy_res exp %0d got %0d", exp_r.busy, got.busy); errors++; end
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || hold_off > 0)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic write_half(input logic [HALF_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_half_period_ticks <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    half_ticks = (v == '0) ? 1 : int'(v);
  endtask

  task automatic drain();
    while (tick_q.size() > 0 || pins_expected.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // command tick that opens a transaction
  task automatic queue_transfer(input logic [ACT_W-1:0] act, input int cnt);
    tick_item_t t;
    t = rand_tick(0, 1);
    t.action = act;
    t.count = BCNT_W'(cnt);
    tick_q.push_back(t);
  endtask

  task automatic run_ticks(input int n, input bit cmd_ok, input bit ack_bias);
    repeat (n) tick_q.push_back(rand_tick(cmd_ok && $urandom_range(30, 0) == 0, ack_bias));
  endtask

  initial begin
    tick_item_t t;
    predictor_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: write with two bytes, read with count zero, idle-time reserved action
    t = '0; t.action = ACT_RSVD; tick_q.push_back(t);
    queue_transfer(ACT_WRITE, 2); run_ticks(40, 0, 1);
    queue_transfer(ACT_READ, 0); run_ticks(40, 0, 1);
    t = '0; t.action = ACT_WRITE; t.addr = 8'hFF; t.count = 16'hFFFF; t.sda = 1'b1;
    tick_q.push_back(t);
    t.action = ACT_READ; tick_q.push_back(t);  // ignored while busy
    run_ticks(30, 0, 0);
    t = '0; t.sda = 1'b1; repeat (30) tick_q.push_back(t);
    drain();

    write_half(16'd0);
    queue_transfer(ACT_WRITE, 1);
    repeat (30) begin t = rand_tick(0, 1); t.tx_ready = 1'b0; tick_q.push_back(t); end
    run_ticks(30, 0, 1);
    drain();

    write_half(16'd3);
    queue_transfer(ACT_READ, 2);
    run_ticks(80, 1, 1);
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_off = 40;
    run_ticks(60, 1, 1);
    drain();

    // wide period: start a write, then shorten the period so it runs out
    write_half(16'hFFFF);
    queue_transfer(ACT_WRITE, 0);
    run_ticks(30, 0, 1);
    drain();

    write_half(16'd1);
    run_ticks(60, 1, 1);
    run_ticks(30, 1, 0);
    drain();
    write_half(16'd2);
    quiet = 1'b1;
    run_ticks(80, 1, 1);
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pins_expected.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/i2cm_pkg.sv
src/i2cm_front.sv
src/i2cm_engine.sv
src/i2c_master_transaction_engine.sv
src/i2cm_checker.sv
sim/tb_top.sv
